@@ hw/rtl/lfht_pkg.sv @@
`timescale 1ns / 1ps
// Package for the lowest-free handle table: sizes, operation and status codes,
// and the group priority encoder used by the free-slot scan. No dependencies.
package lfht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int HANDLE_BITS = 32;

  localparam int SLOT_IN_W = 8;
  localparam int SLOT_W    = $clog2(TABLE_DEPTH);
  localparam int HW_W      = SLOT_W + 1;

  // Free-slot scan looks at one group of occupancy bits per cycle
  localparam int GROUP  = 8;
  localparam int OFF_W  = $clog2(GROUP);
  localparam int GROUPS = TABLE_DEPTH / GROUP;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_CLOSE = 2'd1;
  localparam op_t OP_SET   = 2'd2;
  localparam op_t OP_GET   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_BEYOND = 2'd3;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [OFF_W-1:0] first_set(input logic [GROUP-1:0] bits);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int j = GROUP - 1; j >= 0; j--) begin
      if (bits[j]) idx = OFF_W'(j);
    end
    return idx;
  endfunction

endpackage

@@ hw/rtl/lfht_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lfht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lowest_free_handle_table_core.sv @@
`timescale 1ns / 1ps
// Lowest-free handle table. Close and set run through S_EXEC and S_FIN to the result;
// get adds S_READ (one registered RAM read); allocate adds the S_SCAN free-slot scan,
// which checks GROUP occupancy bits per cycle over up to GROUPS groups.
// One item at a time; a new item is taken as soon as the previous result is
// registered. Synchronous reset clears the mark and all occupancy bits at once.
// Depends on lfht_pkg and lfht_ram.
module lowest_free_handle_table_core
  import lfht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_operation,
  input  logic [SLOT_IN_W-1:0]   in_slot,
  input  logic [HANDLE_BITS-1:0] in_handle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLOT_W-1:0]      out_slot_out,
  output logic [HANDLE_BITS-1:0] out_handle_out,
  output logic [1:0]             out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [SLOT_IN_W-1:0]   slot_r, slot_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [GRP_W-1:0]       grp_r, grp_nxt;
  logic [HW_W-1:0]        hw_r, hw_nxt;
  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic [HANDLE_BITS-1:0] res_handle_r, res_handle_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r, out_handle_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic                   ram_re;
  logic [HANDLE_BITS-1:0] ram_rdata;

  logic [SLOT_W-1:0]      slot_idx;
  logic                   beyond;
  logic                   below_slot;
  logic [GROUP-1:0]       grp_bits;
  logic [GROUP-1:0]       cand;
  logic [OFF_W-1:0]       pick;
  logic [HW_W-1:0]        next_base;
  logic                   last_grp;
  logic                   full;
  logic                   out_free;
  logic                   hit;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot_out   = out_slot_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

  assign slot_idx   = slot_r[SLOT_W-1:0];
  assign beyond     = ({1'b0, slot_r} >= (SLOT_IN_W + 1)'(TABLE_DEPTH));
  assign below_slot = ({1'b0, slot_idx} < hw_r);
  assign full       = (hw_r == HW_W'(TABLE_DEPTH));
  assign out_free   = !out_valid_r || !out_stall;
  assign hit        = below_slot && occ_r[slot_idx];

  // Scan unit: free slots below the mark within the current group
  assign grp_bits = occ_r[grp_r*GROUP +: GROUP];
  always_comb begin
    for (int j = 0; j < GROUP; j++) begin
      cand[j] = !grp_bits[j] && ({1'b0, grp_r, OFF_W'(j)} < hw_r);
    end
  end
  assign pick      = first_set(cand);
  assign next_base = {1'b0, grp_r, {OFF_W{1'b0}}} + HW_W'(GROUP);
  assign last_grp  = (grp_r == GRP_W'(GROUPS - 1)) || (next_base >= hw_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    handle_nxt     = handle_r;
    grp_nxt        = grp_r;
    hw_nxt         = hw_r;
    occ_nxt        = occ_r;
    res_slot_nxt   = res_slot_r;
    res_handle_nxt = res_handle_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_idx;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          slot_nxt   = in_slot;
          handle_nxt = in_handle;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        res_slot_nxt   = slot_idx;
        res_handle_nxt = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_FIN;
        if (op_r == OP_ALLOC) begin
          grp_nxt   = '0;
          state_nxt = S_SCAN;
        end else if (beyond) begin
          res_status_nxt = ST_BEYOND;
        end else begin
          case (op_r)
            OP_CLOSE: begin
              if (!hit) res_status_nxt = ST_EMPTY;
              else      occ_nxt[slot_idx] = 1'b0;
            end
            OP_SET: begin
              ram_we            = 1'b1;
              occ_nxt[slot_idx] = |handle_r;
              if (!below_slot) hw_nxt = {1'b0, slot_idx} + HW_W'(1);
            end
            OP_GET: begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        res_handle_nxt = '0;
        res_status_nxt = ST_OK;
        if (|cand) begin
          ram_we            = 1'b1;
          ram_waddr         = {grp_r, pick};
          occ_nxt[{grp_r, pick}] = |handle_r;
          res_slot_nxt      = {grp_r, pick};
          state_nxt         = S_FIN;
        end else if (last_grp) begin
          state_nxt = S_FIN;
          if (full) begin
            res_slot_nxt   = '0;
            res_status_nxt = ST_FULL;
          end else begin
            ram_we                   = 1'b1;
            ram_waddr                = hw_r[SLOT_W-1:0];
            occ_nxt[hw_r[SLOT_W-1:0]] = |handle_r;
            res_slot_nxt             = hw_r[SLOT_W-1:0];
            hw_nxt                   = hw_r + HW_W'(1);
          end
        end else begin
          grp_nxt = grp_r + GRP_W'(1);
        end
      end
      S_READ: begin
        // occupancy bit masks stale RAM contents left from before reset
        res_handle_nxt = hit ? ram_rdata : '0;
        res_status_nxt = hit ? ST_OK : ST_EMPTY;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_handle_nxt = res_handle_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    handle_r     <= handle_nxt;
    res_slot_r   <= res_slot_nxt;
    res_handle_r <= res_handle_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  lfht_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (handle_r),
    .re    (ram_re),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  // Occupancy bits at or above the mark
  logic [TABLE_DEPTH-1:0] occ_above;
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ_above[i] = occ_r[i] && (HW_W'(i) >= hw_r);
    end
  end

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= HW_W'(TABLE_DEPTH))
    else $error("high-water mark past table depth");

  a_occ_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    occ_above == '0)
    else $error("occupied slot at or above the mark");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == ST_FULL) |-> full)
    else $error("full reported below table depth");

  a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hw_r >= $past(hw_r))
    else $error("high-water mark decreased");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lowest_free_handle_table_core: directed table, then random traffic
// scored by an in-bench table predictor. Depends on lfht_pkg and the core RTL.
module tb_top
  import lfht_pkg::*;
();

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS     = 23;

  typedef struct packed {
    logic [SLOT_W-1:0]      slot;
    logic [HANDLE_BITS-1:0] handle;
    status_t                status;
  } reply_t;

  typedef struct packed {
    op_t                    op;
    logic [SLOT_IN_W-1:0]   slot;
    logic [HANDLE_BITS-1:0] handle;
    logic                   typed;
    reply_t                 reply;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_operation = OP_ALLOC;
  logic [SLOT_IN_W-1:0]   in_slot = '0;
  logic [HANDLE_BITS-1:0] in_handle = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SLOT_W-1:0]      out_slot_out;
  logic [HANDLE_BITS-1:0] out_handle_out;
  logic [1:0]             out_status;

  // Predictor state: table contents and high-water mark
  logic [HANDLE_BITS-1:0] slot_copy [TABLE_DEPTH];
  logic [HW_W-1:0]        mark_copy;

  reply_t      replies_due [$];
  reply_t      head_reply;
  row_t        script [NUM_ROWS];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          long_hold = 1'b0;

  lowest_free_handle_table_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_slot        (in_slot),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_out   (out_slot_out),
    .out_handle_out (out_handle_out),
    .out_status     (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycle_count, replies_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
             field, cycle_count, got, want);
    mismatch_count++;
  endtask

  // Apply one operation to the table copy and return the result it yields
  function automatic reply_t apply_table_op(input op_t op, input logic [SLOT_IN_W-1:0] sl,
                                            input logic [HANDLE_BITS-1:0] h);
    reply_t r;
    logic   placed;
    placed   = 1'b0;
    r.slot   = sl[SLOT_W-1:0];
    r.handle = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!placed && i < mark_copy && slot_copy[i] == '0) begin
          slot_copy[i] = h;
          r.slot       = SLOT_W'(i);
          placed       = 1'b1;
        end
      end
      if (!placed) begin
        if (mark_copy < TABLE_DEPTH) begin
          slot_copy[mark_copy[SLOT_W-1:0]] = h;
          r.slot    = mark_copy[SLOT_W-1:0];
          mark_copy = mark_copy + 1'b1;
        end else begin
          r.slot   = '0;
          r.status = ST_FULL;
        end
      end
    end else if (sl >= TABLE_DEPTH) begin
      r.status = ST_BEYOND;
    end else if (op == OP_CLOSE) begin
      if (sl >= mark_copy || slot_copy[sl[SLOT_W-1:0]] == '0) r.status = ST_EMPTY;
      else slot_copy[sl[SLOT_W-1:0]] = '0;
    end else if (op == OP_SET) begin
      slot_copy[sl[SLOT_W-1:0]] = h;
      if (sl >= mark_copy) mark_copy = HW_W'(sl) + 1'b1;
    end else begin
      if (sl < mark_copy) r.handle = slot_copy[sl[SLOT_W-1:0]];
      if (r.handle == '0) r.status = ST_EMPTY;
    end
    return r;
  endfunction

  // Offer one item and hold it until the transfer; valid stays high on return
  task automatic issue_item(input op_t op, input logic [SLOT_IN_W-1:0] sl,
                            input logic [HANDLE_BITS-1:0] h, input logic typed,
                            input reply_t typed_reply);
    reply_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_slot      <= sl;
    in_handle    <= h;
    do @(posedge clk); while (in_stall);
    predicted = apply_table_op(op, sl, h);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int pct_alloc, input int pct_close,
                            input int pct_set);
    int                     pick;
    int                     roll;
    op_t                    op;
    logic [SLOT_IN_W-1:0]   sl;
    logic [HANDLE_BITS-1:0] h;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < pct_alloc) op = OP_ALLOC;
      else if (pick < pct_alloc + pct_close) op = OP_CLOSE;
      else if (pick < pct_alloc + pct_close + pct_set) op = OP_SET;
      else op = OP_GET;
      // mostly in-range slots, some beyond the depth
      if ($urandom_range(0, 7) == 0) sl = SLOT_IN_W'($urandom_range(0, 255));
      else sl = SLOT_IN_W'($urandom_range(0, TABLE_DEPTH - 1));
      roll = $urandom_range(0, 19);
      if (roll == 0) h = '0;
      else if (roll == 1) h = '1;
      else h = HANDLE_BITS'($urandom);
      issue_item(op, sl, h, 1'b0, '0);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unexpected transfer", {26'd0, out_slot_out}, 32'd0);
      end else begin
        head_reply = replies_due.pop_front();
        if (out_slot_out !== head_reply.slot)
          flag_mismatch("slot_out", {26'd0, out_slot_out}, {26'd0, head_reply.slot});
        if (out_handle_out !== head_reply.handle)
          flag_mismatch("handle_out", out_handle_out, head_reply.handle);
        if (out_status !== head_reply.status)
          flag_mismatch("status", {30'd0, out_status}, {30'd0, head_reply.status});
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) slot_copy[i] = '0;
    mark_copy = '0;

    script = '{
      '{OP_GET,   8'd0,   32'h0000_0000, 1'b1, '{6'd0,  32'h0000_0000, ST_EMPTY}},
      '{OP_CLOSE, 8'd0,   32'h0000_0000, 1'b1, '{6'd0,  32'h0000_0000, ST_EMPTY}},
      '{OP_CLOSE, 8'd255, 32'h0000_0000, 1'b1, '{6'd63, 32'h0000_0000, ST_BEYOND}},
      '{OP_SET,   8'd64,  32'hFFFF_FFFF, 1'b1, '{6'd0,  32'h0000_0000, ST_BEYOND}},
      '{OP_GET,   8'd128, 32'h0000_0000, 1'b1, '{6'd0,  32'h0000_0000, ST_BEYOND}},
      '{OP_ALLOC, 8'd255, 32'hFFFF_FFFF, 1'b1, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_ALLOC, 8'd0,   32'h0000_0000, 1'b1, '{6'd1,  32'h0000_0000, ST_OK}},
      '{OP_ALLOC, 8'd0,   32'h0000_0001, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_GET,   8'd0,   32'h0000_0000, 1'b1, '{6'd0,  32'hFFFF_FFFF, ST_OK}},
      '{OP_SET,   8'd63,  32'hA5A5_5A5A, 1'b1, '{6'd63, 32'h0000_0000, ST_OK}},
      '{OP_GET,   8'd40,  32'h0000_0000, 1'b1, '{6'd40, 32'h0000_0000, ST_EMPTY}},
      '{OP_SET,   8'd10,  32'h0000_0000, 1'b1, '{6'd10, 32'h0000_0000, ST_OK}},
      '{OP_CLOSE, 8'd0,   32'h0000_0000, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_CLOSE, 8'd0,   32'h0000_0000, 1'b1, '{6'd0,  32'h0000_0000, ST_EMPTY}},
      '{OP_ALLOC, 8'd7,   32'h0000_1234, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_ALLOC, 8'd0,   32'h0000_5678, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_SET,   8'd255, 32'h0000_0001, 1'b1, '{6'd63, 32'h0000_0000, ST_BEYOND}},
      '{OP_GET,   8'd63,  32'h0000_0000, 1'b1, '{6'd63, 32'hA5A5_5A5A, ST_OK}},
      '{OP_CLOSE, 8'd63,  32'h0000_0000, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_GET,   8'd63,  32'h0000_0000, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_ALLOC, 8'd0,   32'h8000_0001, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_CLOSE, 8'd1,   32'h0000_0000, 1'b0, '{6'd0,  32'h0000_0000, ST_OK}},
      '{OP_GET,   8'd255, 32'h0000_0000, 1'b1, '{6'd63, 32'h0000_0000, ST_BEYOND}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++)
      issue_item(script[r].op, script[r].slot, script[r].handle, script[r].typed,
                 script[r].reply);
    wait_drained();

    run_random(250, 30, 25, 20);
    wait_drained();

    // Back-to-back items against a long receiver hold-off
    idle_on   = 1'b0;
    long_hold = 1'b1;
    run_random(30, 40, 20, 20);
    idle_on = 1'b1;

    // Allocate-heavy to reach a full table, then close-heavy to open gaps
    run_random(200, 80, 5, 5);
    run_random(200, 15, 60, 10);
    wait_drained();

    // Last stretch at full rate
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_random(150, 35, 25, 15);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
